/* src/swdm_pkg.sv */
// shared types, constants and trig table builder for the sine displacement pixel mapper
package swdm_pkg;

    localparam int COORD_W     = 9;
    localparam int PIXEL_W     = 32;
    localparam int FORCE_W     = 11;
    localparam int SPEED_W     = 8;
    localparam int DIM_W       = 10;
    localparam int ANIM_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int TABLE_DEPTH = 1024;
    localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
    localparam int TRIG_W      = 24;
    localparam int ANIM_WRAP   = 128;

    localparam int MAX_DIM_DEF   = 512;
    localparam int FRAC_BITS_DEF = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

    // request opcodes
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_PIXEL   = 1'b1;

    typedef logic signed [TRIG_W-1:0] t_trig_tab [TABLE_DEPTH];

    // round(sin or cos(i * 6.283 / 128) * 2^frac_bits), half away from zero
    function automatic t_trig_tab build_trig_tab(input bit cosine, input int frac_bits);
        t_trig_tab tab;
        real       ang;
        real       v;
        real       r;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ang = real'(i) * 6.283 / 128.0;
            v   = cosine ? $cos(ang) : $sin(ang);
            v   = v * (2.0 ** frac_bits);
            r   = (v >= 0.0) ? $floor(v + 0.5) : -$floor(-v + 0.5);
            tab[i] = TRIG_W'($rtoi(r));
        end
        return tab;
    endfunction

endpackage

/* src/sine_displacement_pixel_mapper.sv */
// top level: sine wave displacement of pixel coordinates, four stage pipeline
// a pixel request passes the stage 1, 2, 3 and 4 registers before it shows on o_valid
// throughput: one request per cycle; a stalled output freezes the whole pipeline
// frame-advance requests update the animation index at acceptance and give no result
// reset (i_rst_n low, synchronous) clears valid bits, animation index and config
// registers (forces and speed 0, frame size 512)
module sine_displacement_pixel_mapper #(
    parameter int MAX_DIM   = swdm_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = swdm_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_opcode,
    input  logic [swdm_pkg::COORD_W-1:0]     i_src_x,
    input  logic [swdm_pkg::COORD_W-1:0]     i_src_y,
    input  logic [swdm_pkg::PIXEL_W-1:0]     i_src_pixel,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [swdm_pkg::COORD_W-1:0]     o_dest_x,
    output logic [swdm_pkg::COORD_W-1:0]     o_dest_y,
    output logic [swdm_pkg::PIXEL_W-1:0]     o_dest_pixel,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ENTRY_W = FRAC_BITS + 2;
    localparam int PROD_W  = swdm_pkg::FORCE_W + ENTRY_W;
    localparam int OFF_W   = PROD_W - FRAC_BITS;
    localparam int POS_W   = OFF_W + 1;
    localparam logic [PROD_W-1:0] FRAC_MASK = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic [swdm_pkg::DIM_W-1:0] MAX_DIM_L = swdm_pkg::DIM_W'(MAX_DIM);
    localparam logic [swdm_pkg::SPEED_W-1:0] SPEED_MAX = swdm_pkg::SPEED_W'(swdm_pkg::ANIM_WRAP);

    localparam swdm_pkg::t_trig_tab SIN_TAB = swdm_pkg::build_trig_tab(1'b0, FRAC_BITS);
    localparam swdm_pkg::t_trig_tab COS_TAB = swdm_pkg::build_trig_tab(1'b1, FRAC_BITS);

    // configuration
    logic signed [swdm_pkg::FORCE_W-1:0] r_force_x;
    logic signed [swdm_pkg::FORCE_W-1:0] r_force_y;
    logic [swdm_pkg::SPEED_W-1:0]        r_speed;
    logic [swdm_pkg::DIM_W-1:0]          r_frame_width;
    logic [swdm_pkg::DIM_W-1:0]          r_frame_height;
    logic [swdm_pkg::ANIM_W-1:0]         r_anim;
    logic [swdm_pkg::ANIM_W-1:0]         n_anim;

    logic [swdm_pkg::DIM_W-1:0]          w_cl;
    logic [swdm_pkg::DIM_W-1:0]          h_cl;
    logic [swdm_pkg::SPEED_W-1:0]        speed_cl;
    logic [swdm_pkg::ANIM_W:0]           anim_sum;
    logic                                en;
    logic                                accept;

    // stage 1: table addresses
    logic                                r1_valid;
    logic [swdm_pkg::COORD_W-1:0]        r1_x;
    logic [swdm_pkg::COORD_W-1:0]        r1_y;
    logic [swdm_pkg::PIXEL_W-1:0]        r1_pix;
    logic [swdm_pkg::TBL_IDX_W-1:0]      r1_sidx;
    logic [swdm_pkg::TBL_IDX_W-1:0]      r1_cidx;

    // stage 2: table entries
    logic                                r2_valid;
    logic [swdm_pkg::COORD_W-1:0]        r2_x;
    logic [swdm_pkg::COORD_W-1:0]        r2_y;
    logic [swdm_pkg::PIXEL_W-1:0]        r2_pix;
    logic signed [ENTRY_W-1:0]           r2_sin;
    logic signed [ENTRY_W-1:0]           r2_cos;

    // stage 3: products
    logic                                r3_valid;
    logic [swdm_pkg::COORD_W-1:0]        r3_x;
    logic [swdm_pkg::COORD_W-1:0]        r3_y;
    logic [swdm_pkg::PIXEL_W-1:0]        r3_pix;
    logic signed [PROD_W-1:0]            r3_px;
    logic signed [PROD_W-1:0]            r3_py;

    // stage 4: output
    logic                                r4_valid;
    logic [swdm_pkg::COORD_W-1:0]        r4_x;
    logic [swdm_pkg::COORD_W-1:0]        r4_y;
    logic [swdm_pkg::PIXEL_W-1:0]        r4_pix;

    logic signed [PROD_W-1:0]            px_b;
    logic signed [PROD_W-1:0]            py_b;
    logic signed [OFF_W-1:0]             off_x;
    logic signed [OFF_W-1:0]             off_y;
    logic signed [POS_W-1:0]             dx;
    logic signed [POS_W-1:0]             dy;
    logic                                dest_in;

    assign o_stall     = r4_valid & i_stall;
    assign en          = ~o_stall;
    assign accept      = i_valid & en;
    assign o_cfg_ready = 1'b1;

    assign w_cl     = (r_frame_width  > MAX_DIM_L) ? MAX_DIM_L : r_frame_width;
    assign h_cl     = (r_frame_height > MAX_DIM_L) ? MAX_DIM_L : r_frame_height;
    assign speed_cl = (r_speed > SPEED_MAX) ? SPEED_MAX : r_speed;

    always_comb begin
        anim_sum = {1'b0, r_anim} + {1'b0, speed_cl};
        if (anim_sum > (swdm_pkg::ANIM_W + 1)'(swdm_pkg::ANIM_WRAP)) begin
            n_anim = '0;
        end else begin
            n_anim = anim_sum[swdm_pkg::ANIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_x      <= '0;
            r_force_y      <= '0;
            r_speed        <= '0;
            r_frame_width  <= swdm_pkg::DIM_W'(512);
            r_frame_height <= swdm_pkg::DIM_W'(512);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                swdm_pkg::CFG_FORCE_X:      r_force_x <= i_cfg_data;
                swdm_pkg::CFG_FORCE_Y:      r_force_y <= i_cfg_data;
                swdm_pkg::CFG_SPEED:        r_speed <= i_cfg_data[swdm_pkg::SPEED_W-1:0];
                swdm_pkg::CFG_FRAME_WIDTH:  r_frame_width <= i_cfg_data[swdm_pkg::DIM_W-1:0];
                swdm_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[swdm_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anim <= '0;
        end else if (accept && i_opcode == swdm_pkg::OP_ADVANCE) begin
            r_anim <= n_anim;
        end
    end

    // truncate toward zero: bias negative products before the arithmetic shift
    always_comb begin
        px_b    = r3_px + (r3_px[PROD_W-1] ? $signed(FRAC_MASK) : $signed(PROD_W'(0)));
        py_b    = r3_py + (r3_py[PROD_W-1] ? $signed(FRAC_MASK) : $signed(PROD_W'(0)));
        off_x   = OFF_W'(px_b >>> FRAC_BITS);
        off_y   = OFF_W'(py_b >>> FRAC_BITS);
        dx      = $signed({{(POS_W - swdm_pkg::COORD_W){1'b0}}, r3_x}) + {off_x[OFF_W-1], off_x};
        dy      = $signed({{(POS_W - swdm_pkg::COORD_W){1'b0}}, r3_y}) + {off_y[OFF_W-1], off_y};
        dest_in = !dx[POS_W-1] && !dy[POS_W-1]
               && (dx[OFF_W-1:0] < OFF_W'(w_cl))
               && (dy[OFF_W-1:0] < OFF_W'(h_cl));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid && i_opcode == swdm_pkg::OP_PIXEL
                     && ({1'b0, i_src_x} < w_cl) && ({1'b0, i_src_y} < h_cl);
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid && dest_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x    <= i_src_x;
            r1_y    <= i_src_y;
            r1_pix  <= i_src_pixel;
            r1_sidx <= swdm_pkg::TBL_IDX_W'({2'b00, r_anim} + {1'b0, i_src_x});
            r1_cidx <= swdm_pkg::TBL_IDX_W'({2'b00, r_anim} + {1'b0, i_src_y});

            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_pix  <= r1_pix;
            r2_sin  <= ENTRY_W'(SIN_TAB[r1_sidx]);
            r2_cos  <= ENTRY_W'(COS_TAB[r1_cidx]);

            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_pix  <= r2_pix;
            // operands widened first so the full signed product is kept
            r3_px   <= PROD_W'(r_force_x) * PROD_W'(r2_sin);
            r3_py   <= PROD_W'(r_force_y) * PROD_W'(r2_cos);

            r4_x    <= dx[swdm_pkg::COORD_W-1:0];
            r4_y    <= dy[swdm_pkg::COORD_W-1:0];
            r4_pix  <= r3_pix;
        end
    end

    assign o_valid      = r4_valid;
    assign o_dest_x     = r4_x;
    assign o_dest_y     = r4_y;
    assign o_dest_pixel = r4_pix;

endmodule

/* src/swdm_checker.sv */
// port-level checker for the sine displacement pixel mapper, with its bind
module swdm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_stall,
    input logic                             i_opcode,
    input logic [swdm_pkg::COORD_W-1:0]     i_src_x,
    input logic [swdm_pkg::COORD_W-1:0]     i_src_y,
    input logic [swdm_pkg::PIXEL_W-1:0]     i_src_pixel,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [swdm_pkg::COORD_W-1:0]     o_dest_x,
    input logic [swdm_pkg::COORD_W-1:0]     o_dest_y,
    input logic [swdm_pkg::PIXEL_W-1:0]     o_dest_pixel,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [swdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [swdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_dest_x) && $stable(o_dest_y)
            && $stable(o_dest_pixel))
        else $error("stalled result changed");

    // upstream is held back only by a stalled pending result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    // an idle output side never blocks requests
    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall raised with empty output");

    // reset empties the pipeline
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind sine_displacement_pixel_mapper swdm_checker u_swdm_checker (.*);
